FILE: src/v3n_pkg.sv
// Package for the vector normalize core: pipeline depths and shared types.
// Used by v3n_sqrt_pipe, v3n_div_pipe and vector3_normalise_core.
package v3n_pkg;

  // one result bit per stage in each iterative unit
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;
  localparam int QUOT_W      = 31;

  typedef logic [31:0]       word_t;
  typedef logic [63:0]       dword_t;
  typedef logic [QUOT_W-1:0] quot_t;

endpackage

FILE: src/vector3_normalise_core.sv
// Top level of the 3-vector normalize core: squares, sum, root, divide, output.
// Depends on v3n_pkg, v3n_sqrt_pipe and v3n_div_pipe.
//
// Usage:
//   Input request: in_x_in/in_y_in/in_z_in, signed Q16.16, taken when in_valid
//   is high and in_stall is low. Result request: out_x_unit/out_y_unit/
//   out_z_unit in signed Q1.30, out_vec_length = floor of the length in
//   Q16.16, out_was_normalised set when the length exceeds min_length;
//   otherwise the unit components are zero.
//   cfg_min_length is written when cfg_valid is high (cfg_ready is always
//   high); write it only while no request is in flight.
//   The pipeline has 3 front stages (magnitude, squares, sum), 32 root
//   stages, 31 divider stages and the output register. One request per cycle
//   is accepted; the root and divider units produce one bit per stage.
//   The whole pipeline advances as one; when a result waits with out_stall
//   high, every stage holds and in_stall is raised, so nothing is lost.
//   Bubbles move forward while the output register is empty.
//   Reset (rst_n low, synchronous) clears all valid bits and min_length.
module vector3_normalise_core import v3n_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_x_in,
  input  logic [31:0] in_y_in,
  input  logic [31:0] in_z_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_x_unit,
  output logic [31:0] out_y_unit,
  output logic [31:0] out_z_unit,
  output logic [31:0] out_vec_length,
  output logic        out_was_normalised,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_min_length
);

  localparam int LAT = 3 + SQRT_STAGES + DIV_STAGES + 1;

  logic     en;
  logic     vld_r [LAT];
  word_t    min_len_r;

  word_t    mag0_r [3];
  logic     neg0_r [3];
  dword_t   sq1_r  [3];
  word_t    mag1_r [3];
  logic     neg1_r [3];
  dword_t   sum2_r;
  word_t    mag2_r [3];
  logic     neg2_r [3];

  word_t    mag_d_r [SQRT_STAGES][3];
  logic     neg_d_r [SQRT_STAGES][3];
  word_t    root;
  logic     norm;

  word_t    len_d_r  [DIV_STAGES];
  logic     norm_d_r [DIV_STAGES];
  logic     negq_d_r [DIV_STAGES][3];
  quot_t    quot [3];

  word_t    unit_r [3];
  word_t    len_r;
  logic     flag_r;
  word_t    comp_in [3];

  // pipeline moves whenever the output register is free or being taken
  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= '0;
    end else if (cfg_valid) begin
      min_len_r <= cfg_min_length;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  assign comp_in[0] = in_x_in;
  assign comp_in[1] = in_y_in;
  assign comp_in[2] = in_z_in;

  // front stages: magnitude, squares, sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg0_r[i] <= comp_in[i][31];
        mag0_r[i] <= comp_in[i][31] ? 32'(-comp_in[i]) : comp_in[i];
        sq1_r[i]  <= 64'(mag0_r[i]) * 64'(mag0_r[i]);
        mag1_r[i] <= mag0_r[i];
        neg1_r[i] <= neg0_r[i];
        mag2_r[i] <= mag1_r[i];
        neg2_r[i] <= neg1_r[i];
      end
      sum2_r <= sq1_r[0] + sq1_r[1] + sq1_r[2];
    end
  end

  v3n_sqrt_pipe u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum2_r),
    .root     (root)
  );

  // carry components alongside the root stages
  always_ff @(posedge clk) begin
    if (en) begin
      mag_d_r[0] <= mag2_r;
      neg_d_r[0] <= neg2_r;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        mag_d_r[k] <= mag_d_r[k-1];
        neg_d_r[k] <= neg_d_r[k-1];
      end
    end
  end

  assign norm = (root > min_len_r);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3n_div_pipe u_div (
      .clk  (clk),
      .en   (en),
      .mag  (mag_d_r[SQRT_STAGES-1][i]),
      .den  (root),
      .quot (quot[i])
    );
  end

  // carry length, flag and signs alongside the divider
  always_ff @(posedge clk) begin
    if (en) begin
      len_d_r[0]  <= root;
      norm_d_r[0] <= norm;
      negq_d_r[0] <= neg_d_r[SQRT_STAGES-1];
      for (int k = 1; k < DIV_STAGES; k++) begin
        len_d_r[k]  <= len_d_r[k-1];
        norm_d_r[k] <= norm_d_r[k-1];
        negq_d_r[k] <= negq_d_r[k-1];
      end
    end
  end

  // output register: apply sign, zero short vectors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (!norm_d_r[DIV_STAGES-1]) begin
          unit_r[i] <= '0;
        end else if (negq_d_r[DIV_STAGES-1][i]) begin
          unit_r[i] <= 32'(-{1'b0, quot[i]});
        end else begin
          unit_r[i] <= {1'b0, quot[i]};
        end
      end
      len_r  <= len_d_r[DIV_STAGES-1];
      flag_r <= norm_d_r[DIV_STAGES-1];
    end
  end

  assign out_valid          = vld_r[LAT-1];
  assign out_x_unit         = unit_r[0];
  assign out_y_unit         = unit_r[1];
  assign out_z_unit         = unit_r[2];
  assign out_vec_length     = len_r;
  assign out_was_normalised = flag_r;

`ifndef ASSERT_OFF
  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_normalised |->
      out_x_unit == '0 && out_y_unit == '0 && out_z_unit == '0)
    else $error("short vector gave nonzero components");

  a_flag_above: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_normalised |-> out_vec_length > min_len_r)
    else $error("flag set at or below threshold");

  a_flag_below: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_was_normalised |-> out_vec_length <= min_len_r)
    else $error("flag clear above threshold");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");
`endif

endmodule

FILE: src/v3n_sqrt_pipe.sv
// Pipelined integer square root of a 64-bit value, floor result, one root bit per stage.
// Depends on v3n_pkg.
module v3n_sqrt_pipe import v3n_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  dword_t radicand,
  output word_t  root
);

  dword_t      rad_r  [SQRT_STAGES];
  logic [32:0] rem_r  [SQRT_STAGES];
  word_t       root_r [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    dword_t      rad_in;
    logic [32:0] rem_in;
    word_t       root_in;
    logic [34:0] rem_cat;
    logic [34:0] trial;
    logic        ge;

    // stage inputs: first stage starts from an empty root
    if (k == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign rem_cat = {rem_in, rad_in[63:62]};
    assign trial   = {1'b0, root_in, 2'b01};
    assign ge      = (rem_cat >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= {rad_in[61:0], 2'b00};
        rem_r[k]  <= ge ? 33'(rem_cat - trial) : rem_cat[32:0];
        root_r[k] <= {root_in[30:0], ge};
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

FILE: src/v3n_div_pipe.sv
// Pipelined restoring divider: floor(mag * 2^30 / den) for mag <= den, one bit per stage.
// Depends on v3n_pkg.
module v3n_div_pipe import v3n_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  word_t mag,
  input  word_t den,
  output quot_t quot
);

  word_t rem_r [DIV_STAGES];
  word_t den_r [DIV_STAGES];
  quot_t q_r   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    word_t       rem_in;
    word_t       den_in;
    quot_t       q_in;
    logic        nbit;
    logic [32:0] rcat;
    logic        ge;

    // dividend is mag followed by 30 zeros; its top part mag>>1 is below den
    if (k == 0) begin : g_first
      assign rem_in = {1'b0, mag[31:1]};
      assign den_in = den;
      assign q_in   = '0;
      assign nbit   = mag[0];
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = q_r[k-1];
      assign nbit   = 1'b0;
    end

    assign rcat = {rem_in, nbit};
    assign ge   = (rcat >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? 32'(rcat - {1'b0, den_in}) : rcat[31:0];
        den_r[k] <= den_in;
        q_r[k]   <= {q_in[QUOT_W-2:0], ge};
      end
    end
  end

  assign quot = q_r[DIV_STAGES-1];

endmodule
